>>> hw/rtl/zcw_pkg.sv
// shared types and constants for the zero-cross weld pulse sequencer
package zcw_pkg;

   localparam int TICKS_PER_MS = 1000;
   localparam int TICK_W       = $clog2(TICKS_PER_MS + 1);
   localparam int MS_W         = 10;
   localparam int US_W         = 16;
   localparam int PHASE_W      = 3;
   localparam int APB_AW       = 4;
   localparam int APB_DW       = 32;

   localparam logic [1:0] REG_PRE_PULSE  = 2'd0;
   localparam logic [1:0] REG_PAUSE      = 2'd1;
   localparam logic [1:0] REG_WELD_PULSE = 2'd2;
   localparam logic [1:0] REG_PEAK_DELAY = 2'd3;

   localparam logic [MS_W-1:0] PRE_PULSE_RESET  = 10'd50;
   localparam logic [MS_W-1:0] PAUSE_RESET      = 10'd250;
   localparam logic [MS_W-1:0] WELD_PULSE_RESET = 10'd250;
   localparam logic [US_W-1:0] PEAK_DELAY_RESET = 16'd5000;

   typedef struct packed {
      logic start_request;
      logic zero_cross;
      logic button_released;
   } req_type;

   typedef struct packed {
      logic               weld_on;
      logic               busy_res;
      logic [PHASE_W-1:0] phase;
      logic               done_res;
   } rsp_type;

   typedef struct packed {
      logic [MS_W-1:0] pre_pulse_ms;
      logic [MS_W-1:0] pause_ms;
      logic [MS_W-1:0] weld_pulse_ms;
      logic [US_W-1:0] peak_delay_us;
   } cfg_type;

endpackage

>>> hw/rtl/zcw_csr.sv
// apb configuration registers of the weld sequencer
module zcw_csr
   import zcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[APB_AW-1:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre_pulse_ms  <= PRE_PULSE_RESET;
         cfg_ff.pause_ms      <= PAUSE_RESET;
         cfg_ff.weld_pulse_ms <= WELD_PULSE_RESET;
         cfg_ff.peak_delay_us <= PEAK_DELAY_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PRE_PULSE:  cfg_ff.pre_pulse_ms  <= pwdata[MS_W-1:0];
            REG_PAUSE:      cfg_ff.pause_ms      <= pwdata[MS_W-1:0];
            REG_WELD_PULSE: cfg_ff.weld_pulse_ms <= pwdata[MS_W-1:0];
            REG_PEAK_DELAY: cfg_ff.peak_delay_us <= pwdata[US_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PRE_PULSE:  prdata = {{(APB_DW-MS_W){1'b0}}, cfg_ff.pre_pulse_ms};
         REG_PAUSE:      prdata = {{(APB_DW-MS_W){1'b0}}, cfg_ff.pause_ms};
         REG_WELD_PULSE: prdata = {{(APB_DW-MS_W){1'b0}}, cfg_ff.weld_pulse_ms};
         REG_PEAK_DELAY: prdata = {{(APB_DW-US_W){1'b0}}, cfg_ff.peak_delay_us};
         default:        prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/zcw_core.sv
// sequencer state, per-tick update and result register
module zcw_core
   import zcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE      = 3'd0,
      PH_WAIT_LOW  = 3'd1,
      PH_WAIT_HIGH = 3'd2,
      PH_PEAK      = 3'd3,
      PH_PULSE     = 3'd4,
      PH_PAUSE     = 3'd5
   } phase_type;

   localparam logic [TICK_W:0]   TICK_LIMIT = (TICK_W+1)'(TICKS_PER_MS);
   localparam logic [MS_W-1:0]   MS_MAX     = '1;

   phase_type         phase_ff, phase_in;
   logic              main_ff, main_in;
   logic [US_W-1:0]   us_ff, us_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [MS_W-1:0]   ms_ff, ms_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic [TICK_W:0]   tick_inc;
   logic [TICK_W-1:0] tick_step;
   logic [MS_W-1:0]   ms_step;
   logic [MS_W-1:0]   pulse_len;
   logic              pulse_end;
   logic              done;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // millisecond timer advance
   always_comb begin
      tick_inc = {1'b0, tick_ff} + (TICK_W+1)'(1);
      if (tick_inc >= TICK_LIMIT) begin
         tick_step = '0;
         ms_step   = (ms_ff < MS_MAX) ? ms_ff + MS_W'(1) : ms_ff;
      end else begin
         tick_step = tick_inc[TICK_W-1:0];
         ms_step   = ms_ff;
      end
   end

   assign pulse_len = main_ff ? cfg.weld_pulse_ms : cfg.pre_pulse_ms;
   assign pulse_end = (pulse_len == '0) ? req_payload.button_released
                                        : (ms_step >= pulse_len);

   always_comb begin
      phase_in = phase_ff;
      main_in  = main_ff;
      us_in    = us_ff;
      tick_in  = tick_ff;
      ms_in    = ms_ff;
      done     = 1'b0;
      case (phase_ff)
         PH_WAIT_LOW: begin
            if (!req_payload.zero_cross) phase_in = PH_WAIT_HIGH;
         end
         PH_WAIT_HIGH: begin
            if (req_payload.zero_cross) begin
               phase_in = PH_PEAK;
               us_in    = '0;
            end
         end
         PH_PEAK: begin
            if (us_ff >= cfg.peak_delay_us) begin
               phase_in = PH_PULSE;
               tick_in  = '0;
               ms_in    = '0;
            end else begin
               us_in = us_ff + US_W'(1);
            end
         end
         PH_PULSE: begin
            if (pulse_len != '0) begin
               tick_in = tick_step;
               ms_in   = ms_step;
            end
            if (pulse_end) begin
               tick_in = '0;
               ms_in   = '0;
               if (main_ff) begin
                  main_in  = 1'b0;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  main_in  = 1'b1;
                  phase_in = (cfg.pause_ms == '0) ? PH_WAIT_LOW : PH_PAUSE;
               end
            end
         end
         PH_PAUSE: begin
            tick_in = tick_step;
            ms_in   = ms_step;
            if (ms_step >= cfg.pause_ms) begin
               tick_in  = '0;
               ms_in    = '0;
               phase_in = PH_WAIT_LOW;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (req_payload.start_request) begin
               phase_in = PH_WAIT_LOW;
               main_in  = 1'b0;
               us_in    = '0;
               tick_in  = '0;
               ms_in    = '0;
            end
         end
      endcase
   end

   always_comb begin
      rsp_in.weld_on  = (phase_in == PH_PULSE);
      rsp_in.busy_res = (phase_in != PH_IDLE);
      rsp_in.phase    = phase_in;
      rsp_in.done_res = done;
      rsp_valid_in    = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         main_ff      <= 1'b0;
         us_ff        <= '0;
         tick_ff      <= '0;
         ms_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            main_ff  <= main_in;
            us_ff    <= us_in;
            tick_ff  <= tick_in;
            ms_ff    <= ms_in;
         end
      end
      if (accept) rsp_ff <= rsp_in;
   end

endmodule

>>> hw/rtl/zero_cross_weld_pulse_sequencer.sv
// top level of the zero-cross double-pulse weld sequencer
//
// each request is one microsecond tick carrying the zero-cross level, the
// weld button level and a start bit; every request yields exactly one
// response with weld_on, busy_res, phase and done_res after that tick
// the request and response channels use valid/ready; the apb port sets
// pre-pulse, pause, main pulse lengths (ms) and peak delay (us)
// the response is registered and becomes valid in the cycle after the request is accepted
// throughput: one request per cycle while responses are taken, set by the single
// state update between the request port and the response register
// a request is accepted while the response register is empty or being taken,
// so a stalled receiver holds the response and blocks further requests
// reset clears the sequencer to idle, empties the response register and
// loads the register defaults (50, 250, 250 ms, 5000 us)
module zero_cross_weld_pulse_sequencer
   import zcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;

   zcw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   zcw_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
